/* src/doubly_linked_list_with_cursor_core_macros.svh */
// Assertion macros shared by the list core checker.
// No dependencies; include by bare file name.
`ifndef DOUBLY_LINKED_LIST_WITH_CURSOR_CORE_MACROS_SVH
`define DOUBLY_LINKED_LIST_WITH_CURSOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DLLC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DLLC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dllc_pkg.sv */
// Shared types, codes and helpers for the doubly linked list core.
// No dependencies; imported by every module of the block but dllc_ram.
package dllc_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam idx_t NULL_IDX = idx_t'(CAPACITY);

    // request codes
    localparam req_t REQ_APPEND   = 3'd0;
    localparam req_t REQ_DELETE   = 3'd1;
    localparam req_t REQ_NEXT     = 3'd2;
    localparam req_t REQ_PREV     = 3'd3;
    localparam req_t REQ_LIST_FWD = 3'd4;
    localparam req_t REQ_LIST_REV = 3'd5;

    // status codes
    localparam stat_t ST_OK       = 3'd0;
    localparam stat_t ST_EMPTY    = 3'd1;
    localparam stat_t ST_NOTFOUND = 3'd2;
    localparam stat_t ST_END      = 3'd3;
    localparam stat_t ST_START    = 3'd4;
    localparam stat_t ST_FULL     = 3'd5;

    // one node of the store
    typedef struct packed {
        id_t  ident;
        idx_t fwd;
        idx_t bwd;
    } node_t;

    // free slot search result
    typedef struct packed {
        logic  found;
        slot_t slot;
    } free_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APP_TAIL,
        S_APP_NEW,
        S_DEL_CUR,
        S_DEL_HEAD,
        S_DEL_SRCH,
        S_DEL_PRD,
        S_DEL_PWR,
        S_DEL_NRD,
        S_DEL_NWR,
        S_MOVE,
        S_LIST_OUT,
        S_FIN,
        S_EMIT
    } state_t;

    // an index names a node only if it is in range and the node is in use
    function automatic logic idx_live(idx_t i, logic [CAPACITY-1:0] in_use);
        return (i < NULL_IDX) && in_use[i[SLOT_W-1:0]];
    endfunction

endpackage

/* src/dllc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dllc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port: hold data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/dllc_free_find.sv */
// Lowest free slot finder over the in-use bits.
// Depends on dllc_pkg.
module dllc_free_find
    import dllc_pkg::*;
(
    input  logic [CAPACITY-1:0] in_use,
    output free_t               free_o
);

    // scan from the top so the lowest free slot wins
    always_comb begin
        free_o.found = 1'b0;
        free_o.slot  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!in_use[i]) begin
                free_o.found = 1'b1;
                free_o.slot  = slot_t'(i);
            end
        end
    end

endmodule

/* src/doubly_linked_list_with_cursor_core.sv */
// Channel  Dir  Handshake           tdata         tuser        tlast
// s_       in   s_tvalid/s_tready   entry_id      req_type     -
// m_       out  m_tvalid/m_tready   out_id        status       last
//
// Requests are handled one at a time; s_tready is high only while the sequencer is idle.
// Delete walks the list from the head to find the entry.
// A listing gives one id per beat, or a single empty-status beat when the list is empty.
// One memory read port sets the pace.
// Reset clears the in-use bits and the head, tail and cursor at once.
// A stalled result holds in the output register; the next request is taken meanwhile.
// Top level of the doubly linked list core: sequencer, node RAM and slot finder.
// Depends on dllc_pkg, dllc_ram and dllc_free_find.
module doubly_linked_list_with_cursor_core
    import dllc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] entry_id
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_id
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    id_t                 id_reg, id_next;
    idx_t                head_reg, head_next;
    idx_t                tail_reg, tail_next;
    idx_t                cursor_reg, cursor_next;
    logic [CAPACITY-1:0] in_use_reg, in_use_next;
    idx_t                t_reg, t_next;
    slot_t               slot_reg, slot_next;
    idx_t                n_reg, n_next;
    idx_t                p_reg, p_next;
    idx_t                nv_reg, nv_next;
    logic                need_n_reg, need_n_next;
    stat_t               status_reg, status_next;
    logic                hit_reg, hit_next;
    logic                m_tvalid_reg, m_tvalid_next;
    id_t                 m_tdata_reg, m_tdata_next;
    stat_t               m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic  mem_we, mem_re;
    slot_t mem_waddr, mem_raddr;
    node_t mem_wdata, rd;

    free_t free;

    logic  head_live, tail_live, cur_live, list_live, nb_live, fwd_live;
    logic  dir_fwd, rd_match, out_free, is_head, is_tail, need_p_c, need_n_c;
    idx_t  list_start, nb;

    dllc_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    dllc_free_find u_free (
        .in_use (in_use_reg),
        .free_o (free)
    );

    // status of the list pointers and the node just read
    always_comb begin
        head_live  = idx_live(head_reg, in_use_reg);
        tail_live  = idx_live(tail_reg, in_use_reg);
        cur_live   = idx_live(cursor_reg, in_use_reg);
        dir_fwd    = (req_reg == REQ_NEXT) || (req_reg == REQ_LIST_FWD);
        list_start = dir_fwd ? head_reg : tail_reg;
        list_live  = idx_live(list_start, in_use_reg);
        nb         = dir_fwd ? rd.fwd : rd.bwd;
        nb_live    = idx_live(nb, in_use_reg);
        fwd_live   = idx_live(rd.fwd, in_use_reg);
        rd_match   = (rd.ident == id_reg);
        out_free   = !m_tvalid_reg || m_tready;
        is_head    = (t_reg == head_reg);
        is_tail    = (t_reg == tail_reg);
        need_p_c   = !is_head && idx_live(rd.bwd, in_use_reg);
        need_n_c   = fwd_live;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (req_reg)
                    REQ_APPEND: begin
                        if (!free.found) state_next = S_FIN;
                        else if (head_live && tail_live) state_next = S_APP_TAIL;
                        else state_next = S_APP_NEW;
                    end
                    REQ_DELETE: state_next = cur_live ? S_DEL_CUR : S_DEL_HEAD;
                    REQ_NEXT, REQ_PREV: state_next = cur_live ? S_MOVE : S_FIN;
                    REQ_LIST_FWD, REQ_LIST_REV: state_next = list_live ? S_LIST_OUT : S_FIN;
                    default: state_next = S_FIN;
                endcase
            end
            S_APP_TAIL: state_next = S_APP_NEW;
            S_APP_NEW:  state_next = S_FIN;
            S_DEL_CUR:  state_next = S_DEL_HEAD;
            S_DEL_HEAD: state_next = head_live ? S_DEL_SRCH : S_FIN;
            S_DEL_SRCH: begin
                if (rd_match) begin
                    if (need_p_c) state_next = S_DEL_PRD;
                    else if (need_n_c) state_next = S_DEL_NRD;
                    else state_next = S_FIN;
                end else if (!fwd_live) begin
                    state_next = S_FIN;
                end
            end
            S_DEL_PRD:  state_next = S_DEL_PWR;
            S_DEL_PWR:  state_next = need_n_reg ? S_DEL_NRD : S_FIN;
            S_DEL_NRD:  state_next = S_DEL_NWR;
            S_DEL_NWR:  state_next = S_FIN;
            S_MOVE:     state_next = S_FIN;
            S_LIST_OUT: begin
                if (out_free && !nb_live) state_next = S_IDLE;
            end
            S_FIN:      state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    // datapath, memory accesses and result register
    always_comb begin
        req_next      = req_reg;
        id_next       = id_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cursor_next   = cursor_reg;
        in_use_next   = in_use_reg;
        t_next        = t_reg;
        slot_next     = slot_reg;
        n_next        = n_reg;
        p_next        = p_reg;
        nv_next       = nv_reg;
        need_n_next   = need_n_reg;
        status_next   = status_reg;
        hit_next      = hit_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tuser;
                    id_next  = s_tdata;
                end
            end
            S_DECODE: begin
                status_next = ST_OK;
                unique case (req_reg)
                    REQ_APPEND: begin
                        slot_next = free.slot;
                        if (!free.found) begin
                            status_next = ST_FULL;
                        end else if (head_live && tail_live) begin
                            mem_re    = 1'b1;
                            mem_raddr = tail_reg[SLOT_W-1:0];
                        end
                    end
                    REQ_DELETE: begin
                        if (cur_live) begin
                            mem_re    = 1'b1;
                            mem_raddr = cursor_reg[SLOT_W-1:0];
                        end
                    end
                    REQ_NEXT, REQ_PREV: begin
                        if (cur_live) begin
                            mem_re    = 1'b1;
                            mem_raddr = cursor_reg[SLOT_W-1:0];
                        end else begin
                            status_next = ST_EMPTY;
                        end
                    end
                    REQ_LIST_FWD, REQ_LIST_REV: begin
                        if (list_live) begin
                            mem_re    = 1'b1;
                            mem_raddr = list_start[SLOT_W-1:0];
                        end else begin
                            status_next = ST_EMPTY;
                        end
                    end
                    default: status_next = ST_OK;
                endcase
            end
            // link the old tail to the new slot
            S_APP_TAIL: begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg[SLOT_W-1:0];
                mem_wdata = '{ident: rd.ident, fwd: idx_t'(slot_reg), bwd: rd.bwd};
            end
            // write the new node and move head, tail and cursor
            S_APP_NEW: begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = '{ident: id_reg, fwd: NULL_IDX,
                              bwd: head_live ? tail_reg : NULL_IDX};
                in_use_next[slot_reg] = 1'b1;
                tail_next = idx_t'(slot_reg);
                if (!head_live) head_next = idx_t'(slot_reg);
                if (!cur_live) cursor_next = head_live ? head_reg : idx_t'(slot_reg);
            end
            // step the cursor off a matching entry
            S_DEL_CUR: begin
                if (rd_match) cursor_next = rd.fwd;
            end
            S_DEL_HEAD: begin
                if (!head_live) begin
                    status_next = ST_EMPTY;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = head_reg[SLOT_W-1:0];
                    t_next    = head_reg;
                end
            end
            // walk from the head; unlink on the first match
            S_DEL_SRCH: begin
                if (rd_match) begin
                    n_next      = rd.fwd;
                    p_next      = rd.bwd;
                    nv_next     = is_head ? NULL_IDX : rd.bwd;
                    need_n_next = need_n_c;
                    in_use_next[t_reg[SLOT_W-1:0]] = 1'b0;
                    if (is_head) begin
                        head_next = rd.fwd;
                        if (!fwd_live) tail_next = NULL_IDX;
                    end else if (is_tail) begin
                        tail_next = rd.bwd;
                    end
                    if (cursor_reg == t_reg) cursor_next = NULL_IDX;
                end else if (fwd_live) begin
                    t_next    = rd.fwd;
                    mem_re    = 1'b1;
                    mem_raddr = rd.fwd[SLOT_W-1:0];
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            S_DEL_PRD: begin
                mem_re    = 1'b1;
                mem_raddr = p_reg[SLOT_W-1:0];
            end
            S_DEL_PWR: begin
                mem_we    = 1'b1;
                mem_waddr = p_reg[SLOT_W-1:0];
                mem_wdata = '{ident: rd.ident, fwd: n_reg, bwd: rd.bwd};
            end
            S_DEL_NRD: begin
                mem_re    = 1'b1;
                mem_raddr = n_reg[SLOT_W-1:0];
            end
            S_DEL_NWR: begin
                mem_we    = 1'b1;
                mem_waddr = n_reg[SLOT_W-1:0];
                mem_wdata = '{ident: rd.ident, fwd: rd.fwd, bwd: nv_reg};
            end
            // advance the cursor if a neighbor exists
            S_MOVE: begin
                if (nb_live) begin
                    cursor_next = nb;
                    status_next = ST_OK;
                end else begin
                    status_next = dir_fwd ? ST_END : ST_START;
                end
            end
            // emit one listed id per beat and fetch the next node
            S_LIST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd.ident;
                    m_tuser_next  = ST_OK;
                    m_tlast_next  = !nb_live;
                    if (nb_live) begin
                        mem_re    = 1'b1;
                        mem_raddr = nb[SLOT_W-1:0];
                    end
                end
            end
            // fetch the id under the cursor
            S_FIN: begin
                hit_next = cur_live;
                if (cur_live) begin
                    mem_re    = 1'b1;
                    mem_raddr = cursor_reg[SLOT_W-1:0];
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = hit_reg ? rd.ident : '0;
                    m_tuser_next  = status_reg;
                    m_tlast_next  = 1'b1;
                end
            end
            default: begin
                status_next = status_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= NULL_IDX;
            tail_reg     <= NULL_IDX;
            cursor_reg   <= NULL_IDX;
            in_use_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cursor_reg   <= cursor_next;
            in_use_reg   <= in_use_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        id_reg      <= id_next;
        t_reg       <= t_next;
        slot_reg    <= slot_next;
        n_reg       <= n_next;
        p_reg       <= p_next;
        nv_reg      <= nv_next;
        need_n_reg  <= need_n_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* src/dllc_checker.sv */
// Port-level checks for the doubly linked list core, bound to the top level.
// Depends on dllc_pkg and doubly_linked_list_with_cursor_core_macros.svh.
`include "doubly_linked_list_with_cursor_core_macros.svh"

module dllc_checker
    import dllc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result beat holds its value
    `DLLC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result beat changed while stalled")

    // a taken request blocks the input for at least the next cycle
    `DLLC_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "request taken on consecutive cycles")

    // no new request while a listing is still running
    `DLLC_ASSERT_NOW(a_list_blocks, aclk, aresetn, m_tvalid && !m_tlast, !s_tready,
        "request taken in the middle of a listing")

    // only listed ids come as non-final beats, and they carry ok status
    `DLLC_ASSERT_NOW(a_list_status, aclk, aresetn, m_tvalid && !m_tlast, m_tuser == ST_OK,
        "non-final beat without ok status")

endmodule

bind doubly_linked_list_with_cursor_core dllc_checker u_dllc_checker (.*);
